/* design/assert_macros.svh */
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication; the property is off while dis is high.
`define BHD_ASSERT_IMP(lbl, clk, dis, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication; the property is off while dis is high.
`define BHD_ASSERT_NEXT(lbl, clk, dis, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* design/bhd_pkg.sv */
// Shared constants, types and codes of the ball hold detector.
package bhd_pkg;

  localparam int SAMPLE_BITS   = 16;
  localparam int RUN_BITS      = 8;
  localparam int ID_BITS       = 16;
  localparam int ALPHA_BITS    = 17;
  localparam int LEVEL_BITS    = 15;
  localparam int DEBOUNCE_BITS = 8;
  localparam int FRAC_BITS     = 16;

  localparam int CFG_DATA_BITS  = ALPHA_BITS;
  localparam int CFG_INDEX_BITS = 3;
  localparam int EVENT_BITS     = 2;

  // Signed product of the widened alpha and a sample, with room for the sum.
  localparam int ACC_BITS   = ALPHA_BITS + 1 + SAMPLE_BITS;
  localparam int SHIFT_BITS = ACC_BITS - FRAC_BITS;
  localparam int CMP_BITS   = (SAMPLE_BITS > LEVEL_BITS + 1) ? SAMPLE_BITS : LEVEL_BITS + 1;
  localparam int RUNCMP_BITS = (RUN_BITS > DEBOUNCE_BITS) ? RUN_BITS : DEBOUNCE_BITS;

  localparam logic [ALPHA_BITS-1:0] ALPHA_ONE = ALPHA_BITS'(1 << FRAC_BITS);
  localparam logic [RUN_BITS-1:0]   RUN_MAX   = {RUN_BITS{1'b1}};

  // Configuration register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] REG_ROLLER_ID      = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FILTER_ALPHA   = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DETECT_LEVEL   = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LOST_LEVEL     = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DEBOUNCE_COUNT = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [ID_BITS-1:0]       RST_ROLLER_ID      = 16'd12;
  localparam logic [ALPHA_BITS-1:0]    RST_FILTER_ALPHA   = 17'd19661;
  localparam logic [LEVEL_BITS-1:0]    RST_DETECT_LEVEL   = 15'd435;
  localparam logic [LEVEL_BITS-1:0]    RST_LOST_LEVEL     = 15'd256;
  localparam logic [DEBOUNCE_BITS-1:0] RST_DEBOUNCE_COUNT = 8'd3;

  // Hold event codes.
  localparam logic [EVENT_BITS-1:0] EV_NONE   = 2'd0;
  localparam logic [EVENT_BITS-1:0] EV_DETECT = 2'd1;
  localparam logic [EVENT_BITS-1:0] EV_LOST   = 2'd2;

  typedef struct packed {
    logic [ID_BITS-1:0]       roller_id;
    logic [ALPHA_BITS-1:0]    filter_alpha;
    logic [LEVEL_BITS-1:0]    detect_level;
    logic [LEVEL_BITS-1:0]    lost_level;
    logic [DEBOUNCE_BITS-1:0] debounce_count;
  } cfg_t;

endpackage

/* design/bhd_cfg_regs.sv */
// Configuration register file of the ball hold detector.
module bhd_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [bhd_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [bhd_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  output bhd_pkg::cfg_t                       cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.roller_id      <= bhd_pkg::RST_ROLLER_ID;
      cfg.filter_alpha   <= bhd_pkg::RST_FILTER_ALPHA;
      cfg.detect_level   <= bhd_pkg::RST_DETECT_LEVEL;
      cfg.lost_level     <= bhd_pkg::RST_LOST_LEVEL;
      cfg.debounce_count <= bhd_pkg::RST_DEBOUNCE_COUNT;
    end else if (cfg_write) begin
      case (cfg_index)
        bhd_pkg::REG_ROLLER_ID:
          cfg.roller_id <= cfg_data[bhd_pkg::ID_BITS-1:0];
        bhd_pkg::REG_FILTER_ALPHA:
          cfg.filter_alpha <= cfg_data[bhd_pkg::ALPHA_BITS-1:0];
        bhd_pkg::REG_DETECT_LEVEL:
          cfg.detect_level <= cfg_data[bhd_pkg::LEVEL_BITS-1:0];
        bhd_pkg::REG_LOST_LEVEL:
          cfg.lost_level <= cfg_data[bhd_pkg::LEVEL_BITS-1:0];
        bhd_pkg::REG_DEBOUNCE_COUNT:
          cfg.debounce_count <= cfg_data[bhd_pkg::DEBOUNCE_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* design/bhd_filter.sv */
// Exponential low-pass filter with first-sample priming.
module bhd_filter (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   update,
  input  logic signed [bhd_pkg::SAMPLE_BITS-1:0] sample,
  input  logic [bhd_pkg::ALPHA_BITS-1:0]         alpha,
  output logic signed [bhd_pkg::SAMPLE_BITS-1:0] filt_next
);

  logic signed [bhd_pkg::SAMPLE_BITS-1:0] filter_value;
  logic                                   filter_primed;
  logic [bhd_pkg::ALPHA_BITS-1:0]         alpha_c;
  logic [bhd_pkg::ALPHA_BITS-1:0]         beta;
  logic signed [bhd_pkg::ACC_BITS-1:0]    prod_new;
  logic signed [bhd_pkg::ACC_BITS-1:0]    prod_old;
  logic signed [bhd_pkg::ACC_BITS-1:0]    acc;
  logic signed [bhd_pkg::SHIFT_BITS-1:0]  rounded;
  logic signed [bhd_pkg::SAMPLE_BITS-1:0] blended;

  localparam logic signed [bhd_pkg::ACC_BITS-1:0] HALF_LSB =
    bhd_pkg::ACC_BITS'(1 << (bhd_pkg::FRAC_BITS - 1));
  localparam logic signed [bhd_pkg::SHIFT_BITS-1:0] SAT_HI =
    bhd_pkg::SHIFT_BITS'((1 << (bhd_pkg::SAMPLE_BITS - 1)) - 1);
  localparam logic signed [bhd_pkg::SHIFT_BITS-1:0] SAT_LO =
    -bhd_pkg::SHIFT_BITS'(1 << (bhd_pkg::SAMPLE_BITS - 1));

  always_comb begin
    alpha_c  = (alpha > bhd_pkg::ALPHA_ONE) ? bhd_pkg::ALPHA_ONE : alpha;
    beta     = bhd_pkg::ALPHA_ONE - alpha_c;
    prod_new = $signed({1'b0, alpha_c}) * sample;
    prod_old = $signed({1'b0, beta}) * filter_value;
    // Adding one half before the arithmetic shift rounds ties upward.
    acc      = prod_new + prod_old + HALF_LSB;
    rounded  = bhd_pkg::SHIFT_BITS'(acc >>> bhd_pkg::FRAC_BITS);
    if (rounded > SAT_HI) begin
      blended = SAT_HI[bhd_pkg::SAMPLE_BITS-1:0];
    end else if (rounded < SAT_LO) begin
      blended = SAT_LO[bhd_pkg::SAMPLE_BITS-1:0];
    end else begin
      blended = rounded[bhd_pkg::SAMPLE_BITS-1:0];
    end
    filt_next = filter_primed ? blended : sample;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_value  <= '0;
      filter_primed <= 1'b0;
    end else if (update) begin
      filter_value  <= filt_next;
      filter_primed <= 1'b1;
    end
  end

endmodule

/* design/bhd_debounce.sv */
// Threshold compare, debounce run counters and the holding flag.
module bhd_debounce (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   update,
  input  logic signed [bhd_pkg::SAMPLE_BITS-1:0] filt,
  input  bhd_pkg::cfg_t                          cfg,
  output logic                                   hold_next,
  output logic [bhd_pkg::EVENT_BITS-1:0]         event_next
);

  logic [bhd_pkg::RUN_BITS-1:0]         detect_run;
  logic [bhd_pkg::RUN_BITS-1:0]         lost_run;
  logic                                 hold_flag;
  logic [bhd_pkg::RUN_BITS-1:0]         detect_run_next;
  logic [bhd_pkg::RUN_BITS-1:0]         lost_run_next;
  logic signed [bhd_pkg::CMP_BITS-1:0]  filt_x;
  logic signed [bhd_pkg::CMP_BITS-1:0]  detect_x;
  logic signed [bhd_pkg::CMP_BITS-1:0]  lost_x;
  logic [bhd_pkg::RUNCMP_BITS-1:0]      need;

  always_comb begin
    filt_x   = bhd_pkg::CMP_BITS'(filt);
    detect_x = bhd_pkg::CMP_BITS'($signed({1'b0, cfg.detect_level}));
    lost_x   = bhd_pkg::CMP_BITS'($signed({1'b0, cfg.lost_level}));
    need     = bhd_pkg::RUNCMP_BITS'(cfg.debounce_count);
    detect_run_next = '0;
    lost_run_next   = '0;
    hold_next       = hold_flag;
    // The detect test wins when the two thresholds overlap.
    if (filt_x >= detect_x) begin
      detect_run_next = (detect_run == bhd_pkg::RUN_MAX) ? detect_run : detect_run + 1'b1;
      if (bhd_pkg::RUNCMP_BITS'(detect_run_next) >= need) begin
        hold_next = 1'b1;
      end
    end else if (filt_x <= lost_x) begin
      lost_run_next = (lost_run == bhd_pkg::RUN_MAX) ? lost_run : lost_run + 1'b1;
      if (bhd_pkg::RUNCMP_BITS'(lost_run_next) >= need) begin
        hold_next = 1'b0;
      end
    end
    if (hold_next == hold_flag) begin
      event_next = bhd_pkg::EV_NONE;
    end else if (hold_next) begin
      event_next = bhd_pkg::EV_DETECT;
    end else begin
      event_next = bhd_pkg::EV_LOST;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      detect_run <= '0;
      lost_run   <= '0;
      hold_flag  <= 1'b0;
    end else if (update) begin
      detect_run <= detect_run_next;
      lost_run   <= lost_run_next;
      hold_flag  <= hold_next;
    end
  end

endmodule

/* design/ball_hold_detector.sv */
// Top level of the ball hold detector: input register, datapath, result register.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+------------------------------------------
//   input    | in_valid / in_ready     | device_id, current_sample
//   result   | out_valid / out_ready   | holding, filtered_current, hold_event
//   config   | cfg_write               | cfg_index, cfg_data
//
// A report is taken into the input register and processed in the next cycle,
// where its result is written into the result register; one report per cycle
// is sustained while out_ready stays high. The filter,
// counters and flag update in the same cycle as the result register, so the
// following report already sees the new state.
// Reports from other device ids leave the input register without a result.
// A stalled result holds the input register, which then stops accepting.
// Synchronous reset restores register defaults and clears all filter state.
module ball_hold_detector (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [bhd_pkg::ID_BITS-1:0]            device_id,
  input  logic signed [bhd_pkg::SAMPLE_BITS-1:0] current_sample,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic                                   holding,
  output logic signed [bhd_pkg::SAMPLE_BITS-1:0] filtered_current,
  output logic [bhd_pkg::EVENT_BITS-1:0]         hold_event,
  input  logic                                   cfg_write,
  input  logic [bhd_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [bhd_pkg::CFG_DATA_BITS-1:0]      cfg_data
);

  bhd_pkg::cfg_t                          cfg;
  logic                                   s1_valid;
  logic [bhd_pkg::ID_BITS-1:0]            s1_id;
  logic signed [bhd_pkg::SAMPLE_BITS-1:0] s1_sample;
  logic                                   s1_match;
  logic                                   s1_fire;
  logic                                   upd;
  logic                                   out_free;
  logic signed [bhd_pkg::SAMPLE_BITS-1:0] filt_next;
  logic                                   hold_next;
  logic [bhd_pkg::EVENT_BITS-1:0]         event_next;

  bhd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  always_comb begin
    s1_match = (s1_id == cfg.roller_id);
    out_free = !out_valid || out_ready;
    // A report for another device needs no result slot and always drains.
    s1_fire  = s1_valid && (out_free || !s1_match);
    upd      = s1_fire && s1_match;
    in_ready = !s1_valid || s1_fire;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_id     <= device_id;
      s1_sample <= current_sample;
    end
  end

  bhd_filter u_filter (
    .clk       (clk),
    .rst       (rst),
    .update    (upd),
    .sample    (s1_sample),
    .alpha     (cfg.filter_alpha),
    .filt_next (filt_next)
  );

  bhd_debounce u_debounce (
    .clk        (clk),
    .rst        (rst),
    .update     (upd),
    .filt       (filt_next),
    .cfg        (cfg),
    .hold_next  (hold_next),
    .event_next (event_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (upd) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      holding          <= hold_next;
      filtered_current <= filt_next;
      hold_event       <= event_next;
    end
  end

endmodule

/* design/bhd_checker.sv */
// Port-level checker for the ball hold detector, bound to the top level.
`include "assert_macros.svh"

module bhd_checker (
  input logic                                   clk,
  input logic                                   rst,
  input logic                                   out_valid,
  input logic                                   out_ready,
  input logic                                   holding,
  input logic signed [bhd_pkg::SAMPLE_BITS-1:0] filtered_current,
  input logic [bhd_pkg::EVENT_BITS-1:0]         hold_event
);

  // A stalled result keeps its valid and its payload.
  `BHD_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready,
    out_valid && $stable(holding) && $stable(filtered_current) && $stable(hold_event))

  // A detect event always comes with the flag set, a lost event with it clear.
  `BHD_ASSERT_IMP(a_event_flag, clk, rst, out_valid && hold_event != bhd_pkg::EV_NONE,
    (hold_event == bhd_pkg::EV_DETECT && holding) ||
    (hold_event == bhd_pkg::EV_LOST && !holding))

  // A result that transfers with the flag set is never directly followed by a detect result.
  `BHD_ASSERT_NEXT(a_no_double_detect, clk, rst,
    out_valid && out_ready && holding,
    !(out_valid && hold_event == bhd_pkg::EV_DETECT))

  // Reset leaves no result pending.
  `BHD_ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !out_valid)

endmodule

bind ball_hold_detector bhd_checker u_bhd_checker (.*);
